FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge of clk while rstn is high.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that prop never holds at a rising edge of clk while rstn is high.
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

FILE: rtl/core/stip_pkg.sv
`timescale 1ns / 1ps

package stip_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned END_OFF_W = 16;
  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned DIGIT_W   = 7;
  localparam int unsigned PHASE_W   = 3;

  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_AFTER0 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_NEED   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STOP   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BAD    = 3'd6;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd99;
  localparam logic [DIGIT_W-1:0] LETTER_BASE = 7'd10;

  localparam logic [1:0] ADDR_RADIX = 2'd0;

  // Value of a digit character, NO_DIGIT for anything else.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = DIGIT_W'(c - CH_UP_A) + LETTER_BASE;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = DIGIT_W'(c - CH_LO_A) + LETTER_BASE;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/string_to_integer_parser_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte-serial strtol-style parser. One string byte is taken per cycle and a
// new byte may follow in every cycle, except that the byte that ends the
// string (a zero byte or tlast) stalls the input while a result still waits
// downstream; that byte then loads the result register. The rate is set by
// the update stage, where each digit costs one 64 by 6 bit multiply-add on
// the accumulator between the input register and the state.
module string_to_integer_parser_unit
  import stip_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] character
  input  logic                   s_axis_tlast,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [VALUE_W+END_OFF_W-1:0] m_axis_tdata, // [63:0] value, [79:64] end_offset
  output logic                   m_axis_tuser    // [0] end_offset_valid
);

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};
  localparam logic [31:0] EndOffMax = 32'(16'hFFFF);

  logic [RADIX_W-1:0] radix_q;

  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [VALUE_W-1:0]     acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [RADIX_W-1:0]     base_q, base_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   zp_q, zp_d;

  logic                   out_valid_q;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [END_OFF_W-1:0]   off_q, off_d;
  logic                   offv_q, offv_d;

  logic fin;
  logic adv;

  assign pready = 1'b1;
  assign prdata = 32'(radix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RADIX) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  assign fin           = (char_q == CH_NUL) || last_q;
  assign adv           = in_valid_q && (!fin || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic               done;
    logic               inc;
    logic [31:0]        pos_ext;
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    base_d  = base_q;
    pos_d   = pos_q;
    zp_d    = zp_q;
    d       = digit_of(char_q);
    done    = 1'b0;
    inc     = 1'b0;
    value_d = '0;
    off_d   = '0;
    offv_d  = 1'b0;
    pos_ext = '0;

    if (char_q != CH_NUL) begin
      if (phase_d == PH_SIGN) begin
        phase_d = PH_FIRST;
        if (char_q == CH_MINUS) begin
          neg_d = 1'b1;
          inc   = 1'b1;
          done  = 1'b1;
        end else if (char_q == CH_PLUS) begin
          inc  = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && phase_d == PH_FIRST) begin
        if (radix_q == RADIX_AUTO) begin
          if (char_q == CH_ZERO) begin
            inc     = 1'b1;
            zp_d    = 1'b1;
            phase_d = PH_AFTER0;
            done    = 1'b1;
          end else begin
            base_d = BASE_DEC;
          end
        end else begin
          base_d = radix_q;
        end
        if (!done) begin
          phase_d = PH_NEED;
        end
      end
      if (!done && phase_d == PH_AFTER0) begin
        zp_d    = 1'b0;
        phase_d = PH_NEED;
        if (char_q == CH_LO_X || char_q == CH_UP_X) begin
          base_d = BASE_HEX;
          inc    = 1'b1;
          done   = 1'b1;
        end else begin
          base_d = BASE_OCT;
        end
      end
      if (!done && phase_d == PH_NEED) begin
        if (base_d < BASE_MIN || base_d > BASE_MAX) begin
          phase_d = PH_BAD;
          done    = 1'b1;
        end else begin
          phase_d = PH_DIGITS;
        end
      end
      if (!done && phase_d == PH_DIGITS) begin
        if (d >= DIGIT_W'(base_d)) begin
          phase_d = PH_STOP;
        end else begin
          acc_d = acc_d * VALUE_W'(base_d) + VALUE_W'(d);
          inc   = 1'b1;
        end
      end
    end

    if (inc && pos_d != OffMax) begin
      pos_d = pos_d + 1'b1;
    end

    if (fin) begin
      if (phase_d == PH_DIGITS || phase_d == PH_STOP) begin
        pos_ext = 32'(pos_d);
        value_d = neg_d ? (~acc_d + 1'b1) : acc_d;
        off_d   = (pos_ext > EndOffMax) ? EndOffMax[END_OFF_W-1:0] : pos_ext[END_OFF_W-1:0];
        offv_d  = 1'b1;
      end
      phase_d = PH_SIGN;
      acc_d   = '0;
      neg_d   = 1'b0;
      base_d  = '0;
      pos_d   = '0;
      zp_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGN;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= '0;
      pos_q   <= '0;
      zp_q    <= 1'b0;
    end else if (adv) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
      zp_q    <= zp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin) begin
      value_q <= value_d;
      off_q   <= off_d;
      offv_q  <= offv_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {off_q, value_q};
  assign m_axis_tuser  = offv_q;

  `ASSERT_AT(a_unset_is_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "result without offset is not zero")
  `ASSERT_AT(a_clear_after_end, clk_i, rst_ni, adv && fin |=> phase_q == PH_SIGN && pos_q == '0 && acc_q == '0, "string state not cleared after end")
  `ASSERT_NEVER(a_ready_when_held, clk_i, rst_ni, in_valid_q && !adv && s_axis_tready, "input taken while held byte stalls")
  `ASSERT_AT(a_result_loaded, clk_i, rst_ni, adv && fin |=> m_axis_tvalid, "string end gave no result")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import stip_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CHOKE_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam logic [6:0]  NOT_A_DIGIT  = 7'h7F;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } text_byte_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [END_OFF_W-1:0] end_offset;
    logic                 offset_ok;
  } parse_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = ADDR_RADIX;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [CHAR_W-1:0]             s_axis_tdata  = '0;  // [7:0] character
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [VALUE_W+END_OFF_W-1:0]  m_axis_tdata;  // [63:0] value, [79:64] end_offset
  logic                          m_axis_tuser;  // [0] end_offset_valid

  string_to_integer_parser_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  text_byte_t    text_bytes[$];
  parse_result_t pending_results[$];
  int unsigned   queued_cnt   = 0;
  int unsigned   accepted_cnt = 0;
  int unsigned   mismatches   = 0;
  int unsigned   cycles       = 0;
  int unsigned   hold_left    = 0;
  logic          steady       = 1'b0;
  logic          choke_req    = 1'b0;
  logic          choke_done   = 1'b0;

  // parser mirror
  logic [RADIX_W-1:0]   radix_shadow = RADIX_RESET;
  logic [PHASE_W-1:0]   scan_phase   = PH_SIGN;
  logic [VALUE_W-1:0]   acc_value    = '0;
  logic                 minus_seen   = 1'b0;
  logic [RADIX_W-1:0]   base_latched = '0;
  logic [END_OFF_W-1:0] consumed     = '0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [6:0] char_weight(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] folded;
    folded = c | 8'h20;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {3'b000, c[3:0]};
    end
    if (folded >= CH_LO_A && folded <= CH_LO_Z) begin
      return 7'(folded - CH_LO_A + 8'd10);
    end
    return NOT_A_DIGIT;
  endfunction

  task automatic count_byte();
    if (consumed != '1) begin
      consumed = consumed + 1'b1;
    end
  endtask

  task automatic step_parser(input logic [CHAR_W-1:0] c, input logic fin);
    logic [6:0] d;
    logic       taken;
    taken = 1'b0;
    if (c != CH_NUL) begin
      if (scan_phase == PH_SIGN) begin
        scan_phase = PH_FIRST;
        if (c == CH_MINUS) begin
          minus_seen = 1'b1;
          count_byte();
          taken = 1'b1;
        end else if (c == CH_PLUS) begin
          count_byte();
          taken = 1'b1;
        end
      end
      if (!taken && scan_phase == PH_FIRST) begin
        if (radix_shadow == RADIX_AUTO) begin
          if (c == CH_ZERO) begin
            count_byte();
            scan_phase = PH_AFTER0;
            taken = 1'b1;
          end else begin
            base_latched = BASE_DEC;
          end
        end else begin
          base_latched = radix_shadow;
        end
        if (!taken) scan_phase = PH_NEED;
      end
      if (!taken && scan_phase == PH_AFTER0) begin
        scan_phase = PH_NEED;
        if (c == CH_LO_X || c == CH_UP_X) begin
          base_latched = BASE_HEX;
          count_byte();
          taken = 1'b1;
        end else begin
          base_latched = BASE_OCT;
        end
      end
      if (!taken && scan_phase == PH_NEED) begin
        if (base_latched < BASE_MIN || base_latched > BASE_MAX) begin
          scan_phase = PH_BAD;
          taken = 1'b1;
        end else begin
          scan_phase = PH_DIGITS;
        end
      end
      if (!taken && scan_phase == PH_DIGITS) begin
        d = char_weight(c);
        if (d >= {1'b0, base_latched}) begin
          scan_phase = PH_STOP;
        end else begin
          acc_value = acc_value * VALUE_W'(base_latched) + VALUE_W'(d);
          count_byte();
        end
      end
    end
    if (c == CH_NUL || fin) begin
      if (scan_phase == PH_DIGITS || scan_phase == PH_STOP) begin
        pending_results.push_back('{value:      minus_seen ? 64'd0 - acc_value : acc_value,
                                    end_offset: consumed,
                                    offset_ok:  1'b1});
      end else begin
        pending_results.push_back('{value: '0, end_offset: '0, offset_ok: 1'b0});
      end
      scan_phase   = PH_SIGN;
      acc_value    = '0;
      minus_seen   = 1'b0;
      base_latched = '0;
      consumed     = '0;
    end
  endtask

  // sender: advance when the current byte is taken or nothing is offered
  always @(posedge clk_i) begin : byte_feed
    text_byte_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_parser(s_axis_tdata, s_axis_tlast);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (text_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
          nxt = text_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.ch;
          s_axis_tlast  <= nxt.fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_sink
    if (choke_req && !choke_done) begin
      hold_left     <= CHOKE_CYCLES;
      choke_done    <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  always @(posedge clk_i) begin : result_check
    parse_result_t got;
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{value:      m_axis_tdata[VALUE_W-1:0],
              end_offset: m_axis_tdata[VALUE_W+END_OFF_W-1:VALUE_W],
              offset_ok:  m_axis_tuser};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: value=%h end_offset=%0d valid=%b",
                   got.value, got.end_offset, got.offset_ok);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.end_offset !== want.end_offset ||
            got.offset_ok !== want.offset_ok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: exp value=%h end_offset=%0d valid=%b",
                     want.value, want.end_offset, want.offset_ok);
            $display("                 got value=%h end_offset=%0d valid=%b",
                     got.value, got.end_offset, got.offset_ok);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_byte(input logic [CHAR_W-1:0] c, input logic fin);
    text_bytes.push_back('{ch: c, fin: fin});
    queued_cnt++;
  endtask

  task automatic queue_text(input string s, input logic fin_on_last);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], fin_on_last && (i == s.len() - 1));
    end
    if (!fin_on_last) push_byte(CH_NUL, 1'b0);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CHAR_W'(v - 10);
  endfunction

  task automatic queue_random_string(input int radix_val);
    logic [CHAR_W-1:0] s[$];
    int                eff;
    int                ndig;
    int                ending;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) s.push_back(CHAR_W'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       s.push_back(CH_MINUS);
        1:       s.push_back(CH_PLUS);
        default: ;
      endcase
      eff = radix_val;
      if (radix_val == RADIX_AUTO) begin
        case ($urandom_range(0, 3))
          0: begin
            s.push_back(CH_ZERO);
            eff = BASE_OCT;
          end
          1: begin
            s.push_back(CH_ZERO);
            s.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            eff = BASE_HEX;
          end
          default: eff = BASE_DEC;
        endcase
      end
      if (eff < BASE_MIN || eff > BASE_MAX) eff = BASE_MAX;
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 6);
      repeat (ndig) s.push_back(digit_char($urandom_range(0, eff - 1)));
      if ($urandom_range(0, 3) == 0) s.push_back(CHAR_W'($urandom_range(1, 255)));
    end
    ending = $urandom_range(0, 2);
    for (int i = 0; i < s.size(); i++) begin
      push_byte(s[i], ending == 2 && i == s.size() - 1);
    end
    if (ending != 2 || s.size() == 0) push_byte(CH_NUL, ending == 1);
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_RADIX;
    pwdata  <= {26'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    radix_shadow = val;
  endtask

  initial begin : stimulus
    int radix_plan[12];
    int unsigned phase_start;
    radix_plan = '{0, 10, 16, 2, 36, 8, 1, 37, 63, 0, 0, 0};
    radix_plan[10] = $urandom_range(2, 36);
    radix_plan[11] = $urandom_range(0, 63);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default base
    push_byte(CH_NUL, 1'b0);
    queue_text("-", 1'b1);
    queue_text("+9", 1'b1);
    queue_text("z", 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_NUL, 1'b1);

    // prefix detection
    wait_idle();
    write_radix(RADIX_AUTO);
    queue_text("0", 1'b1);
    queue_text("0x", 1'b1);
    queue_text("0X1f", 1'b1);
    queue_text("017", 1'b0);
    queue_text("-9", 1'b1);

    // out-of-range bases
    wait_idle();
    write_radix(6'd1);
    queue_text("5", 1'b1);
    wait_idle();
    write_radix(6'd63);
    queue_text("Z", 1'b1);

    // base change after the base is latched
    wait_idle();
    write_radix(BASE_MAX);
    push_byte(CH_ZERO + 8'd1, 1'b0);
    wait_idle();
    write_radix(BASE_MIN);
    push_byte(CH_UP_Z, 1'b1);

    for (int p = 0; p < 12; p++) begin
      wait_idle();
      write_radix(RADIX_W'(radix_plan[p]));
      steady = (p == 3);
      if (p == 5) choke_req = 1'b1;
      phase_start = queued_cnt;
      while (queued_cnt < phase_start + PHASE_ITEMS) queue_random_string(radix_plan[p]);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
